// ===== rtl/core/flr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_pkg
// Shared constants, register indexes, opcodes and the command/status bundles
// that pass between the line rasterizer controller and its datapath.
// ----------------------------------------------------------------------------
package flr_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int SCREEN_BITS = 13;
    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd640;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic load;
        logic emit;
        logic div_step;
        logic div_finish;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic nonzero;
    } sts_t;

endpackage

// ===== rtl/core/flr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_dp
// Segment setup, restoring slope divider, DDA stepper, screen registers and
// the output pixel register of the line rasterizer.
// ----------------------------------------------------------------------------
module flr_dp #(
    parameter int COORD_BITS = flr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = flr_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  flr_pkg::cmd_t                        cmd,
    output flr_pkg::sts_t                        sts,
    input  logic signed [COORD_BITS-1:0]         start_x,
    input  logic signed [COORD_BITS-1:0]         start_y,
    input  logic signed [COORD_BITS-1:0]         end_x,
    input  logic signed [COORD_BITS-1:0]         end_y,
    input  logic                                 cfg_write,
    input  logic [flr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [flr_pkg::SCREEN_BITS-1:0]      cfg_data,
    output logic signed [COORD_BITS-1:0]         pixel_x,
    output logic signed [COORD_BITS-1:0]         pixel_y,
    output logic                                 on_screen,
    output logic                                 last
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = C + 1;
    localparam int NW = C + F;
    localparam int AW = C + F + 1;
    localparam int SW = F + 2;
    localparam int PW = C + 2;
    localparam int SB = flr_pkg::SCREEN_BITS;
    localparam int CW = (PW > SB + 1) ? PW : SB + 1;

    logic [SB-1:0]           screen_w_reg;
    logic [SB-1:0]           screen_h_reg;

    logic signed [C-1:0]     origin_x_reg;
    logic signed [C-1:0]     origin_y_reg;
    logic                    major_is_y_reg;
    logic                    step_neg_reg;
    logic                    slope_neg_reg;
    logic [C-1:0]            major_end_reg;
    logic [C-1:0]            major_index_reg;
    logic signed [SW-1:0]    slope_reg;
    logic signed [AW-1:0]    acc_reg;
    logic                    active_reg;
    logic [C-1:0]            rem_reg;
    logic [NW-1:0]           num_reg;
    logic [F:0]              quot_reg;

    logic signed [C-1:0]     pixel_x_reg;
    logic signed [C-1:0]     pixel_y_reg;
    logic                    on_screen_reg;
    logic                    last_reg;

    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic [DW-1:0]           adx;
    logic [DW-1:0]           ady;
    logic                    major_y;
    logic signed [DW-1:0]    lng;
    logic signed [DW-1:0]    shrt;
    logic [DW-1:0]           alng;
    logic [DW-1:0]           ashrt;

    logic [C:0]              shifted;
    logic [C:0]              diff;
    logic                    fits;
    logic [C-1:0]            rem_next;
    logic [F:0]              quot_next;
    logic signed [SW-1:0]    qext;
    logic signed [SW-1:0]    slope_next;

    logic signed [DW-1:0]    idx_s;
    logic signed [DW-1:0]    major_off;
    logic signed [AW-1:0]    acc_sh;
    logic signed [DW-1:0]    minor_off;
    logic signed [C-1:0]     major_org;
    logic signed [C-1:0]     minor_org;
    logic signed [PW-1:0]    major_c;
    logic signed [PW-1:0]    minor_c;
    logic signed [PW-1:0]    px;
    logic signed [PW-1:0]    py;
    logic signed [CW-1:0]    px_e;
    logic signed [CW-1:0]    py_e;
    logic signed [CW-1:0]    w_e;
    logic signed [CW-1:0]    h_e;
    logic                    on_next;
    logic [C:0]              idx_inc;
    logic                    fin;
    logic signed [AW-1:0]    acc_next;

    // segment setup
    always_comb
    begin
        dx      = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
        dy      = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
        adx     = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady     = dy[DW-1] ? DW'(-dy) : DW'(dy);
        major_y = ady > adx;
        lng     = major_y ? dy : dx;
        shrt    = major_y ? dx : dy;
        alng    = major_y ? ady : adx;
        ashrt   = major_y ? adx : ady;
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        shifted    = {rem_reg, num_reg[NW-1]};
        fits       = shifted >= {1'b0, major_end_reg};
        diff       = shifted - {1'b0, major_end_reg};
        rem_next   = fits ? diff[C-1:0] : shifted[C-1:0];
        quot_next  = {quot_reg[F-1:0], fits};
        qext       = $signed({1'b0, quot_next});
        slope_next = slope_neg_reg ? -qext : qext;
    end

    // DDA step
    always_comb
    begin
        idx_s     = $signed({1'b0, major_index_reg});
        major_off = step_neg_reg ? -idx_s : idx_s;
        acc_sh    = acc_reg >>> F;
        minor_off = $signed(acc_sh[DW-1:0]);
        major_org = major_is_y_reg ? origin_y_reg : origin_x_reg;
        minor_org = major_is_y_reg ? origin_x_reg : origin_y_reg;
        major_c   = PW'(major_org) + PW'(major_off);
        minor_c   = PW'(minor_org) + PW'(minor_off);
        px        = major_is_y_reg ? minor_c : major_c;
        py        = major_is_y_reg ? major_c : minor_c;
        px_e      = CW'(px);
        py_e      = CW'(py);
        w_e       = $signed({{(CW - SB){1'b0}}, screen_w_reg});
        h_e       = $signed({{(CW - SB){1'b0}}, screen_h_reg});
        on_next   = !px[PW-1] && (px_e < w_e) && !py[PW-1] && (py_e < h_e);
        idx_inc   = {1'b0, major_index_reg} + {{C{1'b0}}, 1'b1};
        fin       = idx_inc >= {1'b0, major_end_reg};
        acc_next  = acc_reg + AW'(slope_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= flr_pkg::SCREEN_WIDTH_RESET;
            screen_h_reg <= flr_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == flr_pkg::REG_SCREEN_WIDTH)
            begin
                screen_w_reg <= cfg_data;
            end
            else if (cfg_index == flr_pkg::REG_SCREEN_HEIGHT)
            begin
                screen_h_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            major_is_y_reg  <= 1'b0;
            step_neg_reg    <= 1'b0;
            slope_neg_reg   <= 1'b0;
            major_end_reg   <= '0;
            major_index_reg <= '0;
            slope_reg       <= '0;
            acc_reg         <= '0;
            active_reg      <= 1'b0;
            rem_reg         <= '0;
            num_reg         <= '0;
            quot_reg        <= '0;
        end
        else if (cmd.load)
        begin
            origin_x_reg    <= start_x;
            origin_y_reg    <= start_y;
            major_is_y_reg  <= major_y;
            step_neg_reg    <= lng[DW-1];
            slope_neg_reg   <= shrt[DW-1];
            major_end_reg   <= alng[C-1:0];
            major_index_reg <= '0;
            slope_reg       <= '0;
            acc_reg         <= '0;
            active_reg      <= 1'b0;
            rem_reg         <= '0;
            num_reg         <= {ashrt[C-1:0], {F{1'b0}}};
            quot_reg        <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            quot_reg <= quot_next;
            if (cmd.div_finish)
            begin
                slope_reg  <= slope_next;
                active_reg <= 1'b1;
            end
        end
        else if (cmd.emit)
        begin
            major_index_reg <= idx_inc[C-1:0];
            acc_reg         <= acc_next;
            if (fin)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_x_reg   <= px[C-1:0];
            pixel_y_reg   <= py[C-1:0];
            on_screen_reg <= on_next;
            last_reg      <= fin;
        end
    end

    assign sts.active  = active_reg;
    assign sts.nonzero = (dx != '0) || (dy != '0);

    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign on_screen = on_screen_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/flr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_ctrl
// Controller of the line rasterizer: input handshake, divider sequencing and
// the valid flag of the output register.
// ----------------------------------------------------------------------------
module flr_ctrl #(
    parameter int DIV_STEPS = flr_pkg::COORD_BITS_DEF + flr_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          opcode,
    input  logic          out_stall,
    output logic          in_stall,
    output logic          out_valid,
    output flr_pkg::cmd_t cmd,
    input  flr_pkg::sts_t sts
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             in_fire;
    logic             cnt_last;

    assign in_stall = (state_reg == S_DIV) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign cnt_last = cnt_reg == CNT_W'(DIV_STEPS - 1);

    always_comb
    begin
        cmd.load       = in_fire && (opcode == flr_pkg::OP_START);
        cmd.emit       = in_fire && (opcode == flr_pkg::OP_STEP) && sts.active;
        cmd.div_step   = state_reg == S_DIV;
        cmd.div_finish = (state_reg == S_DIV) && cnt_last;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load && sts.nonzero)
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/fixed_point_line_rasterizer.sv =====
`timescale 1ns / 1ps
// A step beat's pixel shows on the output in the cycle after the beat is accepted.
// Throughput: one step beat per cycle, held back by a stalled output register or by
// a running slope division. A nonzero-length start beat runs the one-bit-per-cycle
// restoring slope divider, during which input stalls; a zero-length start beat skips
// the division. Reset clears the segment (idle, no pixels) and sets the screen to
// 640 x 480.
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer
// DDA line rasterizer with a fixed-point slope: start beats load a segment,
// step beats yield one pixel each while the segment is active, with an on-screen flag and a last flag.
// ----------------------------------------------------------------------------
module fixed_point_line_rasterizer #(
    parameter int COORD_BITS = flr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = flr_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic signed [COORD_BITS-1:0]         start_x,
    input  logic signed [COORD_BITS-1:0]         start_y,
    input  logic signed [COORD_BITS-1:0]         end_x,
    input  logic signed [COORD_BITS-1:0]         end_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [COORD_BITS-1:0]         pixel_x,
    output logic signed [COORD_BITS-1:0]         pixel_y,
    output logic                                 on_screen,
    output logic                                 last,
    input  logic                                 cfg_write,
    input  logic [flr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [flr_pkg::SCREEN_BITS-1:0]      cfg_data
);

    flr_pkg::cmd_t cmd;
    flr_pkg::sts_t sts;

    flr_ctrl #(
        .DIV_STEPS (COORD_BITS + FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    flr_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .on_screen (on_screen),
        .last      (last)
    );

    a_finish_activates: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_finish |=> sts.active)
        else $error("segment not active after slope division");

    a_zero_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !sts.nonzero) |=> !sts.active)
        else $error("zero-length segment became active");

    a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && sts.nonzero) |=> (in_stall && !sts.active))
        else $error("input taken while slope division runs");

    a_emit_not_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !cmd.div_step)
        else $error("pixel stepped during slope division");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line rasterizer. Random and hand-picked segments
// are loaded and stepped through. A scoreboard tracks the DDA state in step
// with every accepted beat and compares each pixel with its own prediction.
// Screen sizes change between phases, and each phase idles and stalls the two
// sides differently.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB = flr_pkg::COORD_BITS_DEF;
    localparam int FB = flr_pkg::FRAC_BITS_DEF;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic [flr_pkg::SCREEN_BITS-1:0] screen_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   on_screen;
        logic   last;
    } pixel_t;

    class raster_scoreboard;
        int          width = 640;
        int          height = 480;
        longint      origin_x;
        longint      origin_y;
        bit          major_is_y;
        longint      major_index;
        longint      major_end;
        bit          step_negative;
        longint      slope;
        longint      accum;
        bit          active;
        pixel_t      pixel_queue[$];
        int          errors;
        int          segments;
        int          pixels;
        int          visible;

        function void set_reg(logic [flr_pkg::CFG_INDEX_BITS-1:0] idx, screen_t val);
            if (idx == flr_pkg::REG_SCREEN_WIDTH)
                width = val;
            else if (idx == flr_pkg::REG_SCREEN_HEIGHT)
                height = val;
        endfunction

        function void trace_beat(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            longint dx;
            longint dy;
            longint adx;
            longint ady;
            longint lng;
            longint shrt;
            longint idx;
            longint mnr;
            longint px;
            longint py;
            pixel_t p;
            if (op == flr_pkg::OP_START)
            begin
                segments++;
                dx = longint'(ex) - longint'(sx);
                dy = longint'(ey) - longint'(sy);
                adx = (dx < 0) ? -dx : dx;
                ady = (dy < 0) ? -dy : dy;
                origin_x = sx;
                origin_y = sy;
                major_is_y = ady > adx;
                lng = major_is_y ? dy : dx;
                shrt = major_is_y ? dx : dy;
                step_negative = lng < 0;
                major_end = (lng < 0) ? -lng : lng;
                major_index = 0;
                accum = 0;
                active = major_end != 0;
                slope = active ? (shrt * (longint'(1) << FB)) / major_end : 0;
            end
            else if (active)
            begin
                idx = step_negative ? -major_index : major_index;
                mnr = accum >>> FB;
                px = major_is_y ? origin_x + mnr : origin_x + idx;
                py = major_is_y ? origin_y + idx : origin_y + mnr;
                p.x = px[CB-1:0];
                p.y = py[CB-1:0];
                p.on_screen = px >= 0 && px < width && py >= 0 && py < height;
                accum += slope;
                major_index++;
                p.last = major_index >= major_end;
                if (p.last)
                    active = 0;
                pixel_queue.push_back(p);
            end
        endfunction

        function void check_pixel(coord_t px, coord_t py, logic on, logic fin);
            pixel_t e;
            if (pixel_queue.size() == 0)
            begin
                errors++;
                $error("pixel with no expectation: x %0d y %0d", px, py);
                return;
            end
            e = pixel_queue.pop_front();
            pixels++;
            if (on)
                visible++;
            if (px !== e.x)
            begin
                errors++;
                $error("pixel_x: expected %0d, got %0d", e.x, px);
            end
            if (py !== e.y)
            begin
                errors++;
                $error("pixel_y: expected %0d, got %0d", e.y, py);
            end
            if (on !== e.on_screen)
            begin
                errors++;
                $error("on_screen: expected %0b, got %0b", e.on_screen, on);
            end
            if (fin !== e.last)
            begin
                errors++;
                $error("last: expected %0b, got %0b", e.last, fin);
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic                               opcode;
    coord_t                             start_x;
    coord_t                             start_y;
    coord_t                             end_x;
    coord_t                             end_y;
    logic                               out_valid;
    logic                               out_stall;
    coord_t                             pixel_x;
    coord_t                             pixel_y;
    logic                               on_screen;
    logic                               last;
    logic                               cfg_write;
    logic [flr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    screen_t                            cfg_data;

    raster_scoreboard sb = new();

    int idle_pct;
    int stall_pct;
    int hold_seq;
    int hold_len;
    int hold_seen;
    int hold_left;
    int beats_sent;

    fixed_point_line_rasterizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .on_screen (on_screen),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // hold off the output for a requested stretch, else stall at random
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.trace_beat(opcode, start_x, start_y, end_x, end_y);
            if (out_valid && !out_stall)
                sb.check_pixel(pixel_x, pixel_y, on_screen, last);
        end
    end

    function automatic coord_t clamp_coord(int v);
        if (v > 4095)
            return 4095;
        if (v < -4096)
            return -4096;
        return coord_t'(v);
    endfunction

    task automatic send_beat(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        beats_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic step_pixels(int n);
        repeat (n)
            send_beat(flr_pkg::OP_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pixel_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_screen(int w, int h);
        repeat (40)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= flr_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= screen_t'(w);
        sb.set_reg(flr_pkg::REG_SCREEN_WIDTH, screen_t'(w));
        @(posedge clk);
        cfg_index <= flr_pkg::REG_SCREEN_HEIGHT;
        cfg_data  <= screen_t'(h);
        sb.set_reg(flr_pkg::REG_SCREEN_HEIGHT, screen_t'(h));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic draw_random(int n);
        int     stop;
        int     kind;
        int     sx;
        int     sy;
        int     ex;
        int     ey;
        int     len;
        int     steps;
        int     pick;
        stop = beats_sent + n;
        while (beats_sent < stop)
        begin
            kind = $urandom_range(99);
            sx = int'($urandom_range(0, sb.width + 40)) - 20;
            sy = int'($urandom_range(0, sb.height + 40)) - 20;
            if (kind < 15)
            begin
                sx = coord_t'($urandom);
                sy = coord_t'($urandom);
                ex = coord_t'($urandom);
                ey = coord_t'($urandom);
            end
            else if (kind < 20)
            begin
                ex = sx;
                ey = sy;
            end
            else if (kind < 80)
            begin
                ex = sx + int'($urandom_range(0, 40)) - 20;
                ey = sy + int'($urandom_range(0, 40)) - 20;
            end
            else
            begin
                ex = sx + int'($urandom_range(0, 400)) - 200;
                ey = sy + int'($urandom_range(0, 400)) - 200;
            end
            sx = clamp_coord(sx);
            sy = clamp_coord(sy);
            ex = clamp_coord(ex);
            ey = clamp_coord(ey);
            len = (ex > sx) ? ex - sx : sx - ex;
            if (((ey > sy) ? ey - sy : sy - ey) > len)
                len = (ey > sy) ? ey - sy : sy - ey;
            pick = $urandom_range(99);
            if (pick < 70)
                steps = len;
            else if (pick < 85)
                steps = len + $urandom_range(1, 3);
            else
                steps = $urandom_range(0, len);
            if (steps > 60)
                steps = 60;
            send_beat(flr_pkg::OP_START, coord_t'(sx), coord_t'(sy), coord_t'(ex),
                      coord_t'(ey));
            step_pixels(steps);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= flr_pkg::OP_START;
        start_x   <= '0;
        start_y   <= '0;
        end_x     <= '0;
        end_y     <= '0;
        cfg_write <= 1'b0;
        cfg_index <= flr_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= '0;
        out_stall <= 1'b0;
        idle_pct  = 0;
        stall_pct <= 0;
        hold_seq  <= 0;
        hold_len  <= 0;
        beats_sent = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        step_pixels(1);
        send_beat(flr_pkg::OP_START, 5, 5, 5, 5);
        step_pixels(1);
        send_beat(flr_pkg::OP_START, -4096, -4096, 4095, 4095);
        step_pixels(2);
        send_beat(flr_pkg::OP_START, 4095, 4095, -4096, -4096);
        step_pixels(2);
        send_beat(flr_pkg::OP_START, 10, 0, 12, -7);
        step_pixels(3);
        send_beat(flr_pkg::OP_START, 0, 3, -5, 2);
        step_pixels(3);
        send_beat(flr_pkg::OP_START, 1, 1, 2, 1);
        step_pixels(2);
        send_beat(flr_pkg::OP_START, 639, 479, 641, 481);
        step_pixels(2);

        // back up the output while a long segment keeps coming
        hold_len <= 250;
        hold_seq <= hold_seq + 1;
        send_beat(flr_pkg::OP_START, 20, -50, -130, 250);
        step_pixels(300);
        wait_drained();

        draw_random(250);

        for (int ph = 1; ph <= 4; ph++)
        begin
            wait_drained();
            unique case (ph)
                1:
                begin
                    set_screen(4096, 4096);
                    idle_pct = 71;
                    stall_pct <= 0;
                end
                2:
                begin
                    set_screen(1, 1);
                    idle_pct = 0;
                    stall_pct <= 71;
                end
                3:
                begin
                    set_screen(0, 4095);
                    idle_pct = 11;
                    stall_pct <= 11;
                end
                default:
                begin
                    set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
                    idle_pct = 0;
                    stall_pct <= 0;
                end
            endcase
            draw_random(300);
        end

        stall_pct <= 0;
        wait_drained();
        repeat (40)
            @(posedge clk);

        $display("Drew %0d segment loads into %0d checked pixels (%0d on screen)",
                 sb.segments, sb.pixels, sb.visible);
        $display("across five screen sizes, including zero and full width, with idling and stalls");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
